FILE: design/psrc_pkg.sv
// Package for the perfect square range counter.
// Field widths, default value width, saturation limit and the
// controller/datapath command and status structs. No dependencies.
package psrc_pkg;

    localparam int unsigned FIELD_W         = 32;
    localparam int unsigned COUNT_W         = 16;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic load_in;    // latch bounds, start root of upper bound
        logic load_lo;    // keep upper root, start root of lower bound minus one
        logic step;       // one digit of the shared root unit
        logic write_out;  // form count into output register
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;  // root unit is on its final digit
    } t_dp_sts;

endpackage

FILE: design/psrc_ctrl.sv
// Controller for the perfect square range counter.
// Sequences two roots on the shared datapath unit and owns both handshakes.
// Depends on psrc_pkg.
module psrc_ctrl
    import psrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_ROOT_HI = 4'b0010,
        S_ROOT_LO = 4'b0100,
        S_DONE    = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_fire;
    logic   w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_fire   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_ROOT_HI;
                end
            end
            S_ROOT_HI: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    o_cmd.load_lo = 1'b1;
                    n_state       = S_ROOT_LO;
                end
            end
            S_ROOT_LO: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.write_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_start_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_ROOT_HI))
        else $error("accepted beat did not start the upper root");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while held");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !w_out_free) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write_out |=> r_out_valid)
        else $error("written result not presented");

endmodule

FILE: design/psrc_dp.sv
// Datapath for the perfect square range counter.
// Bound registers, a shared digit-by-digit square root unit and the
// saturating count output register. Depends on psrc_pkg.
module psrc_dp
    import psrc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic [FIELD_W-1:0] i_range_low,
    input  logic [FIELD_W-1:0] i_range_high,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic [COUNT_W-1:0] o_square_count,
    output logic               o_range_empty
);

    localparam int unsigned STEPS = (VALUE_WIDTH + 1) / 2;
    localparam int unsigned RW    = STEPS;
    localparam int unsigned XW    = 2 * STEPS;
    localparam int unsigned MW    = RW + 2;
    localparam int unsigned PW    = RW + 4;
    localparam int unsigned CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int unsigned SW    = (RW + 1 > COUNT_W + 1) ? RW + 1 : COUNT_W + 1;

    logic [VALUE_WIDTH-1:0] r_lo;
    logic [VALUE_WIDTH-1:0] w_lo_in, w_hi_in, w_lo_dec;
    logic                   r_empty, r_lo_zero;
    logic [XW-1:0]          r_x;
    logic [MW-1:0]          r_rem, w_rem_next;
    logic [RW-1:0]          r_root, r_root_hi, w_root_next;
    logic [CW-1:0]          r_step;
    logic [PW-1:0]          w_pre, w_trial;
    logic                   w_bit;
    logic [SW-1:0]          w_sum;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_out_empty;

    assign w_lo_in  = VALUE_WIDTH'(i_range_low);
    assign w_hi_in  = VALUE_WIDTH'(i_range_high);
    assign w_lo_dec = r_lo - VALUE_WIDTH'(1);

    // one root digit per cycle: bring down a bit pair, try 4*root+1
    assign w_pre       = {r_rem, 2'b00} | PW'(r_x[XW-1 -: 2]);
    assign w_trial     = PW'({r_root, 2'b01});
    assign w_bit       = (w_pre >= w_trial);
    assign w_rem_next  = w_bit ? MW'(w_pre - w_trial) : MW'(w_pre);
    assign w_root_next = RW'({r_root, w_bit});

    assign o_sts.last_step = (r_step == '0);

    always_comb begin
        if (r_lo_zero) begin
            w_sum = SW'(r_root_hi) + SW'(1);
        end else begin
            w_sum = SW'(r_root_hi) - SW'(r_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_lo      <= w_lo_in;
            r_empty   <= (w_lo_in > w_hi_in);
            r_lo_zero <= (w_lo_in == '0);
            r_x       <= XW'(w_hi_in);
            r_rem     <= '0;
            r_root    <= '0;
            r_step    <= CW'(STEPS - 1);
        end else if (i_cmd.load_lo) begin
            r_root_hi <= w_root_next;
            r_x       <= XW'(w_lo_dec);
            r_rem     <= '0;
            r_root    <= '0;
            r_step    <= CW'(STEPS - 1);
        end else if (i_cmd.step) begin
            r_x    <= r_x << 2;
            r_rem  <= w_rem_next;
            r_root <= w_root_next;
            r_step <= r_step - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_out) begin
            if (r_empty) begin
                r_count     <= '0;
                r_out_empty <= 1'b1;
            end else begin
                r_count     <= (w_sum > SW'(COUNT_MAX)) ? COUNT_MAX : w_sum[COUNT_W-1:0];
                r_out_empty <= 1'b0;
            end
        end
    end

    assign o_square_count = r_count;
    assign o_range_empty  = r_out_empty;

endmodule

FILE: design/perfect_square_range_count_unit.sv
// Top level of the perfect square range counter: counts the squares in
// [low, high] as isqrt(high) - isqrt(low - 1). Depends on psrc_pkg,
// psrc_ctrl and psrc_dp.
//
//  port group   dir  beat contents (lowest bits first)
//  s_axis       in   tdata: range_low[31:0], range_high[63:32]
//  m_axis       out  tdata: square_count[15:0]; tuser: range_empty[0]
//
// One beat runs the upper root, then the lower root; both run one digit a
// cycle on a single shared unit.
// Synchronous active-low reset clears the controller and output valid only.
// A new beat is taken while the previous result waits on m_axis; the unit
// holds its finished count if m_axis stays stalled.
module perfect_square_range_count_unit
    import psrc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [2*FIELD_W-1:0] i_s_axis_tdata,  // range_low, range_high
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [COUNT_W-1:0]   o_m_axis_tdata,  // square_count
    output logic                 o_m_axis_tuser   // range_empty
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    psrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    psrc_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_range_low    (i_s_axis_tdata[FIELD_W-1:0]),
        .i_range_high   (i_s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_square_count (o_m_axis_tdata),
        .o_range_empty  (o_m_axis_tuser)
    );

endmodule
